FILE: rtl/core/bpl_pkg.sv
package bpl_pkg;

    // Number of frames in the pool and the width of a frame number.
    localparam int FRAMES  = 16;
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int SCAN_W  = $clog2(FRAMES + 1);

    localparam logic [15:0] PIN_MAX   = 16'hFFFF;
    localparam logic [63:0] STAMP_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_FETCH    = 2'd0,
        OP_ALLOCATE = 2'd1,
        OP_UNPIN    = 2'd2,
        OP_FLUSH    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_HIT          = 3'd0,
        ST_LOADED       = 3'd1,
        ST_NOT_RESIDENT = 3'd2,
        ST_NO_FRAME     = 3'd3,
        ST_PINNED_FLUSH = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_PIN,
        UPD_LOAD,
        UPD_UNPIN,
        UPD_CLEAN
    } upd_kind_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } fsm_t;

    // Search result handed from cell to cell along the chain.
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [FRAME_W-1:0] hit_idx;
        logic [15:0]        hit_pins;
        logic               hit_dirty;
        logic               empty;
        logic [FRAME_W-1:0] empty_idx;
        logic               vic;
        logic [FRAME_W-1:0] vic_idx;
        logic [63:0]        vic_stamp;
        logic               vic_dirty;
        logic [31:0]        vic_page;
    } carry_t;

    // Update command broadcast to all cells at the end of a request.
    typedef struct packed {
        logic               en;
        upd_kind_t          kind;
        logic [FRAME_W-1:0] idx;
        logic [31:0]        page;
        logic [63:0]        stamp;
        logic               mark;
    } upd_t;

endpackage

FILE: rtl/core/bpl_req_if.sv
interface bpl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] page_id;
    logic        dirty_mark;

    modport source (output valid, output op, output page_id, output dirty_mark, input ready);
    modport sink (input valid, input op, input page_id, input dirty_mark, output ready);
endinterface

FILE: rtl/core/bpl_rsp_if.sv
interface bpl_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  frame_index;
    logic        read_needed;
    logic        writeback_needed;
    logic [31:0] writeback_page_id;

    modport source (output valid, output status, output frame_index, output read_needed,
                    output writeback_needed, output writeback_page_id, input ready);
    modport sink (input valid, input status, input frame_index, input read_needed,
                  input writeback_needed, input writeback_page_id, output ready);
endinterface

FILE: rtl/core/buffer_pool_lru_directory_top.sv
// Channel  Direction  Payload
// req      in         op, page_id, dirty_mark
// rsp      out        status, frame_index, read_needed, writeback_needed, writeback_page_id
//
// From transfer to result, the search travels one frame cell per cycle down the
// chain of registered cells, then the update commits once the result can be
// handed to rsp. Requests are handled one at a time.
// Reset empties every frame and sets the use stamp counter to one.
// A result held by a stalled rsp channel delays the commit of the next request.
module buffer_pool_lru_directory_top
    import bpl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bpl_req_if.sink   req,
    bpl_rsp_if.source rsp
);

    fsm_t        state_reg, state_next;
    op_t         op_reg;
    logic [31:0] page_reg;
    logic        mark_reg;
    logic        inject_reg;
    carry_t      res_reg;
    logic [63:0] stamp_cnt_reg;
    logic        stamp_use;
    carry_t      chain [FRAMES+1];
    upd_t        upd;

    logic        rsp_valid_reg;
    status_t     status_reg, status_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic        rd_reg, rd_next;
    logic        wb_reg, wb_next;
    logic [31:0] wbpage_reg, wbpage_next;
    logic        fire;
    logic        accept;

    assign accept      = req.valid && req.ready;
    assign req.ready   = (state_reg == FSM_IDLE);

    // Inject the search at the head of the chain.
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = inject_reg;
    end

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        bpl_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (FRAME_W'(i)),
            .req_page (page_reg),
            .carry_in (chain[i]),
            .carry_out(chain[i+1]),
            .upd      (upd)
        );
    end

    // Request and search result capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(req.op);
            page_reg <= req.page_id;
            mark_reg <= req.dirty_mark;
        end
        if (state_reg == FSM_SCAN && chain[FRAMES].valid)
        begin
            res_reg <= chain[FRAMES];
        end
    end

    // Decision from the finished search.
    always_comb
    begin
        status_next = ST_HIT;
        frame_next  = '0;
        rd_next     = 1'b0;
        wb_next     = 1'b0;
        wbpage_next = 32'd0;
        upd         = '0;
        upd.page    = page_reg;
        upd.stamp   = stamp_cnt_reg;
        upd.mark    = mark_reg;
        stamp_use   = 1'b0;
        fire        = (state_reg == FSM_DONE) && (!rsp_valid_reg || rsp.ready);
        state_next  = state_reg;

        unique case (op_reg)
            OP_FETCH, OP_ALLOCATE:
            begin
                if (res_reg.hit)
                begin
                    frame_next = res_reg.hit_idx;
                    upd.kind   = UPD_PIN;
                    upd.idx    = res_reg.hit_idx;
                    stamp_use  = 1'b1;
                end
                else if (res_reg.empty || res_reg.vic)
                begin
                    status_next = ST_LOADED;
                    frame_next  = res_reg.empty ? res_reg.empty_idx : res_reg.vic_idx;
                    rd_next     = (op_reg == OP_FETCH);
                    if (!res_reg.empty && res_reg.vic_dirty)
                    begin
                        wb_next     = 1'b1;
                        wbpage_next = res_reg.vic_page;
                    end
                    upd.kind  = UPD_LOAD;
                    upd.idx   = frame_next;
                    stamp_use = 1'b1;
                end
                else
                begin
                    status_next = ST_NO_FRAME;
                end
            end
            OP_UNPIN:
            begin
                if (res_reg.hit)
                begin
                    frame_next = res_reg.hit_idx;
                    upd.kind   = UPD_UNPIN;
                    upd.idx    = res_reg.hit_idx;
                end
                else
                begin
                    status_next = ST_NOT_RESIDENT;
                end
            end
            OP_FLUSH:
            begin
                if (!res_reg.hit)
                begin
                    status_next = ST_NOT_RESIDENT;
                end
                else if (res_reg.hit_pins != 16'd0)
                begin
                    status_next = ST_PINNED_FLUSH;
                    frame_next  = res_reg.hit_idx;
                end
                else
                begin
                    frame_next = res_reg.hit_idx;
                    if (res_reg.hit_dirty)
                    begin
                        wb_next     = 1'b1;
                        wbpage_next = page_reg;
                        upd.kind    = UPD_CLEAN;
                        upd.idx     = res_reg.hit_idx;
                    end
                end
            end
            default:
            begin
            end
        endcase
        upd.en = fire;

        unique case (state_reg)
            FSM_IDLE: if (accept) state_next = FSM_SCAN;
            FSM_SCAN: if (chain[FRAMES].valid) state_next = FSM_DONE;
            FSM_DONE: if (fire) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            inject_reg    <= 1'b0;
            stamp_cnt_reg <= 64'd1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= accept;
            if (fire && stamp_use && stamp_cnt_reg != STAMP_MAX)
            begin
                stamp_cnt_reg <= stamp_cnt_reg + 64'd1;
            end
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            frame_reg  <= frame_next;
            rd_reg     <= rd_next;
            wb_reg     <= wb_next;
            wbpage_reg <= wbpage_next;
        end
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.status            = status_reg;
    assign rsp.frame_index       = 4'(frame_reg);
    assign rsp.read_needed       = rd_reg;
    assign rsp.writeback_needed  = wb_reg;
    assign rsp.writeback_page_id = wbpage_reg;

`ifndef ASSERT_OFF
    a_stamp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        stamp_cnt_reg != 64'd0) else $error("stamp counter reached zero");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == FSM_SCAN && inject_reg) else $error("search not started");

    a_chain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FSM_IDLE |-> !chain[FRAMES].valid) else $error("stray search result");
`endif

endmodule

FILE: rtl/core/bpl_cell.sv
module bpl_cell
    import bpl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FRAME_W-1:0] idx,
    input  logic [31:0]        req_page,
    input  carry_t             carry_in,
    output carry_t             carry_out,
    input  upd_t               upd
);

    logic [31:0] page_reg;
    logic        dirty_reg;
    logic [15:0] pins_reg;
    logic [63:0] stamp_reg;
    carry_t      carry_reg;
    carry_t      carry_next;

    // Fold this frame into the running lookup, empty-frame and victim search.
    always_comb
    begin
        carry_next = carry_in;
        if (!carry_in.hit && stamp_reg != 64'd0 && page_reg == req_page)
        begin
            carry_next.hit       = 1'b1;
            carry_next.hit_idx   = idx;
            carry_next.hit_pins  = pins_reg;
            carry_next.hit_dirty = dirty_reg;
        end
        if (!carry_in.empty && stamp_reg == 64'd0)
        begin
            carry_next.empty     = 1'b1;
            carry_next.empty_idx = idx;
        end
        if (stamp_reg != 64'd0 && pins_reg == 16'd0 &&
            (!carry_in.vic || stamp_reg < carry_in.vic_stamp))
        begin
            carry_next.vic       = 1'b1;
            carry_next.vic_idx   = idx;
            carry_next.vic_stamp = stamp_reg;
            carry_next.vic_dirty = dirty_reg;
            carry_next.vic_page  = page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

    assign carry_out = carry_reg;

    // Frame state, cleared by reset and otherwise changed only by an update aimed at this frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= 32'd0;
            dirty_reg <= 1'b0;
            pins_reg  <= 16'd0;
            stamp_reg <= 64'd0;
        end
        else if (upd.en && upd.idx == idx)
        begin
            case (upd.kind)
                UPD_PIN:
                begin
                    if (pins_reg != PIN_MAX)
                    begin
                        pins_reg <= pins_reg + 16'd1;
                    end
                    stamp_reg <= upd.stamp;
                end
                UPD_LOAD:
                begin
                    page_reg  <= upd.page;
                    dirty_reg <= 1'b0;
                    pins_reg  <= 16'd1;
                    stamp_reg <= upd.stamp;
                end
                UPD_UNPIN:
                begin
                    if (pins_reg != 16'd0)
                    begin
                        pins_reg <= pins_reg - 16'd1;
                    end
                    dirty_reg <= dirty_reg | upd.mark;
                end
                UPD_CLEAN:
                begin
                    dirty_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: verif/bpl_tb_pkg.sv
package bpl_tb_pkg;
    import bpl_pkg::*;

    // One expected response of the directory.
    typedef struct {
        status_t     status;
        logic [3:0]  frame_index;
        logic        read_needed;
        logic        writeback_needed;
        logic [31:0] writeback_page_id;
    } dir_rsp_t;

    // Shadow directory and the queue of responses it has predicted.
    class dir_scoreboard;
        logic [31:0] page_of [FRAMES];
        logic        dirty_of [FRAMES];
        logic [15:0] pins_of [FRAMES];
        logic [63:0] stamp_of [FRAMES];
        logic [63:0] use_clock;
        dir_rsp_t    pending_rsp[$];
        int          mismatches;

        function new();
            for (int i = 0; i < FRAMES; i++)
            begin
                page_of[i] = '0;
                dirty_of[i] = 1'b0;
                pins_of[i] = '0;
                stamp_of[i] = '0;
            end
            use_clock = 64'd1;
            mismatches = 0;
        endfunction

        function logic [63:0] take_stamp();
            logic [63:0] s;
            s = use_clock;
            if (use_clock != STAMP_MAX)
                use_clock = use_clock + 64'd1;
            return s;
        endfunction

        function int find_frame(logic [31:0] page);
            for (int i = 0; i < FRAMES; i++)
                if (stamp_of[i] != 0 && page_of[i] == page)
                    return i;
            return -1;
        endfunction

        function int choose_victim();
            int best;
            logic [63:0] low;
            best = -1;
            low = STAMP_MAX;
            for (int i = 0; i < FRAMES; i++)
            begin
                if (stamp_of[i] == 0)
                    return i;
                if (pins_of[i] == 0 && (best < 0 || stamp_of[i] < low))
                begin
                    low = stamp_of[i];
                    best = i;
                end
            end
            return best;
        endfunction

        // Apply one accepted request to the shadow and queue its response.
        function void note_request(op_t op, logic [31:0] page, logic mark);
            dir_rsp_t r;
            int f;
            int v;
            r.status = ST_HIT;
            r.frame_index = '0;
            r.read_needed = 1'b0;
            r.writeback_needed = 1'b0;
            r.writeback_page_id = '0;
            f = find_frame(page);
            if (op == OP_FETCH || op == OP_ALLOCATE)
            begin
                if (f >= 0)
                begin
                    if (pins_of[f] != PIN_MAX)
                        pins_of[f] = pins_of[f] + 16'd1;
                    stamp_of[f] = take_stamp();
                    r.frame_index = f[3:0];
                end
                else
                begin
                    v = choose_victim();
                    if (v < 0)
                        r.status = ST_NO_FRAME;
                    else
                    begin
                        if (stamp_of[v] != 0 && dirty_of[v])
                        begin
                            r.writeback_needed = 1'b1;
                            r.writeback_page_id = page_of[v];
                        end
                        page_of[v] = page;
                        dirty_of[v] = 1'b0;
                        pins_of[v] = 16'd1;
                        stamp_of[v] = take_stamp();
                        r.status = ST_LOADED;
                        r.frame_index = v[3:0];
                        r.read_needed = (op == OP_FETCH);
                    end
                end
            end
            else if (op == OP_UNPIN)
            begin
                if (f < 0)
                    r.status = ST_NOT_RESIDENT;
                else
                begin
                    if (pins_of[f] != 0)
                        pins_of[f] = pins_of[f] - 16'd1;
                    dirty_of[f] = dirty_of[f] | mark;
                    r.frame_index = f[3:0];
                end
            end
            else
            begin
                if (f < 0)
                    r.status = ST_NOT_RESIDENT;
                else if (pins_of[f] != 0)
                begin
                    r.status = ST_PINNED_FLUSH;
                    r.frame_index = f[3:0];
                end
                else
                begin
                    r.frame_index = f[3:0];
                    if (dirty_of[f])
                    begin
                        r.writeback_needed = 1'b1;
                        r.writeback_page_id = page;
                        dirty_of[f] = 1'b0;
                    end
                end
            end
            pending_rsp.push_back(r);
        endfunction

        function void report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endfunction

        // Compare one received response with the oldest prediction.
        function void check_response(logic [2:0] st, logic [3:0] fi, logic rd,
                                     logic wb, logic [31:0] wbp);
            dir_rsp_t e;
            if (pending_rsp.size() == 0)
            begin
                report("response with nothing expected");
                return;
            end
            e = pending_rsp.pop_front();
            if (st !== e.status)
                report($sformatf("status %0d, expected %0d", st, e.status));
            if (fi !== e.frame_index)
                report($sformatf("frame_index %0d, expected %0d", fi, e.frame_index));
            if (rd !== e.read_needed)
                report($sformatf("read_needed %0b, expected %0b", rd, e.read_needed));
            if (wb !== e.writeback_needed)
                report($sformatf("writeback_needed %0b, expected %0b", wb,
                                 e.writeback_needed));
            if (wbp !== e.writeback_page_id)
                report($sformatf("writeback_page_id %h, expected %h", wbp,
                                 e.writeback_page_id));
        endfunction
    endclass
endpackage

FILE: verif/tb.sv
module tb;
    import bpl_pkg::*;
    import bpl_tb_pkg::*;

    logic clk;
    logic rst_n;
    bpl_req_if req ();
    bpl_rsp_if rsp ();
    dir_scoreboard board;
    bit sending_done;
    int hold_off_cycles;
    logic [31:0] page_set [8];

    buffer_pool_lru_directory_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Send one request and wait for its transfer.
    task automatic send_request(op_t op, logic [31:0] page, logic mark);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.page_id <= page;
        req.dirty_mark <= mark;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(op, page, mark);
        @(negedge clk);
    endtask

    // Random page drawn mostly from a small working set so hits are common.
    function automatic logic [31:0] pick_page();
        int k;
        k = $urandom_range(0, 99);
        if (k < 80)
            return page_set[$urandom_range(0, 7)];
        if (k < 90)
            return $urandom_range(0, 40);
        return $urandom();
    endfunction

    // Stimulus.
    initial
    begin
        op_t op;
        board = new();
        sending_done = 0;
        req.valid = 1'b0;
        req.op = OP_FETCH;
        req.page_id = '0;
        req.dirty_mark = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty pool, extremes, fill, clean and dirty evictions, flush cases.
        send_request(OP_UNPIN, 32'd0, 1'b1);
        send_request(OP_FLUSH, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_FETCH, 32'd0, 1'b0);
        send_request(OP_FETCH, 32'd0, 1'b1);
        send_request(OP_FLUSH, 32'd0, 1'b0);
        send_request(OP_UNPIN, 32'd0, 1'b1);
        send_request(OP_UNPIN, 32'd0, 1'b0);
        send_request(OP_UNPIN, 32'd0, 1'b1);
        send_request(OP_FLUSH, 32'd0, 1'b0);
        send_request(OP_FLUSH, 32'd0, 1'b0);
        for (int i = 1; i < FRAMES; i++)
            send_request(i[0] ? OP_ALLOCATE : OP_FETCH, 32'hFFFF_FFF0 + i, 1'b0);
        send_request(OP_FETCH, 32'h1234_5678, 1'b0);
        send_request(OP_UNPIN, 32'hFFFF_FFF3, 1'b1);
        send_request(OP_ALLOCATE, 32'hAAAA_5555, 1'b0);

        // Random part.
        for (int i = 0; i < 8; i++)
            page_set[i] = (i < 4) ? $urandom_range(0, 30) : $urandom();
        for (int n = 0; n < 1400; n++)
        begin
            if (n % 300 == 299)
                for (int i = 0; i < 8; i++)
                    page_set[i] = $urandom();
            case ($urandom_range(0, 9))
                0, 1, 2: op = OP_FETCH;
                3: op = OP_ALLOCATE;
                4, 5, 6, 7: op = OP_UNPIN;
                default: op = OP_FLUSH;
            endcase
            send_request(op, pick_page(), 1'($urandom_range(0, 1)));
        end
        req.valid <= 1'b0;
        sending_done = 1;
    end

    // Response side: random stalls and one long hold-off.
    initial
    begin
        int gap;
        int taken;
        rsp.ready = 1'b0;
        hold_off_cycles = 0;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles == 0 && taken == 300)
            begin
                rsp.ready <= 1'b0;
                repeat (200)
                begin
                    @(negedge clk);
                    hold_off_cycles++;
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
            board.check_response(rsp.status, rsp.frame_index, rsp.read_needed,
                                 rsp.writeback_needed, rsp.writeback_page_id);
            taken++;
        end
    end

    // End of run.
    initial
    begin
        @(posedge rst_n);
        wait (sending_done && board.pending_rsp.size() == 0);
        repeat (40) @(posedge clk);
        if (board.mismatches == 0 && board.pending_rsp.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #1500000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: files.f
rtl/core/bpl_pkg.sv
rtl/core/bpl_req_if.sv
rtl/core/bpl_rsp_if.sv
rtl/core/bpl_cell.sv
rtl/core/buffer_pool_lru_directory_top.sv
verif/bpl_tb_pkg.sv
verif/tb.sv
